// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL, included by ccv_engine. Each macro expects aclk and aresetn
// to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent must hold in the same cycle.
`define ASSERT_SAME_CYCLE(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds, consequent must hold in the following cycle.
`define ASSERT_NEXT_CYCLE(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ccv_pkg.sv -----
`default_nettype none

package ccv_pkg;

    // One kernel row: four signed Q8.8 coefficients, column 0 in the lowest bits.
    typedef logic signed [15:0] coeff_t;
    typedef coeff_t [3:0] coeff_row_t;
    typedef coeff_row_t [3:0] kernel_t;

    // Input command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KERNEL_ROW_0 = 3'd0;
    localparam logic [2:0] CFG_KERNEL_ROW_1 = 3'd1;
    localparam logic [2:0] CFG_KERNEL_ROW_2 = 3'd2;
    localparam logic [2:0] CFG_KERNEL_ROW_3 = 3'd3;
    localparam logic [2:0] CFG_FRAME_ROWS   = 3'd4;
    localparam logic [2:0] CFG_FRAME_COLS   = 3'd5;
    localparam logic [2:0] CFG_MIN_BRIGHT   = 3'd6;
    localparam logic [2:0] CFG_MAX_BRIGHT   = 3'd7;

    localparam logic [8:0] FRAME_SIZE_RESET = 9'd256;
    localparam logic [7:0] MAX_BRIGHT_RESET = 8'd255;

    // Sixteen products of an 8-bit pixel and a 16-bit signed coefficient fit in 28 bits.
    localparam int ACC_W  = 28;
    localparam int PROD_W = 25;
    localparam logic [8:0] MOD_BASE = 9'd255;

    // Settings the engine needs while it works on a query.
    typedef struct packed {
        kernel_t    kernel;
        logic [7:0] min_brightness;
        logic [7:0] max_brightness;
    } win_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/ccv_frame_ram.sv -----
`default_nettype none

// Single-port frame memory with a registered read port.
module ccv_frame_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en && we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !we) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/ccv_engine.sv -----
`default_nettype none
`include "assert_macros.svh"

// Command sequencer: stores pixel writes, walks the kernel taps of a query
// through the frame memory, accumulates, reduces and clamps the result.
module ccv_engine #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256,
    parameter int KERNEL_SIZE = 3,
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ccv_pkg::win_cfg_t cfg,
    input  wire logic [RIW-1:0]    rows_m1,
    input  wire logic [CIW-1:0]    cols_m1,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_cmd,
    input  wire logic [7:0]        s_row,
    input  wire logic [7:0]        s_col,
    input  wire logic [7:0]        s_value,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_value,
    output logic                   m_oof
);

    import ccv_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
    localparam int HALF  = KERNEL_SIZE / 2;
    localparam logic [KW-1:0] K_LAST = KW'(KERNEL_SIZE - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_MOD,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]                row_reg, col_reg;
    logic [KW-1:0]             kr_reg, kc_reg;
    logic                      rd_vld_reg, prod_vld_reg;
    coeff_t                    coeff_d1_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [7:0]                mag_reg;
    logic                      neg_reg;
    logic                      oof_reg;
    logic                      m_tvalid_reg;
    logic [7:0]                m_value_reg;
    logic                      m_oof_reg;

    logic          accept, inside_in, wr_fire, issuing, last_tap, out_free;
    logic [AW-1:0] wr_addr, rd_addr, ram_addr;
    logic [7:0]    ram_rdata;
    logic [14:0]   rt, ct;
    logic [RIW-1:0] ri;
    logic [CIW-1:0] ci;
    coeff_t        coeff_sel;

    logic [ACC_W-1:0]   acc_mag;
    logic [ACC_W-9:0]   q_mag;
    logic [9:0]         s1;
    logic [8:0]         s2;
    logic [7:0]         mag_next;
    logic signed [9:0]  sv, cv;
    logic [7:0]         out_value;

    // Handshake and the write path.
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign inside_in = (32'(s_row) <= 32'(rows_m1)) && (32'(s_col) <= 32'(cols_m1));
    assign wr_fire   = accept && (s_cmd == CMD_WRITE) && inside_in;
    assign wr_addr   = AW'(s_row) * AW'(MAX_COLS) + AW'(s_col);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Tap coordinates, clamped to the frame edges.
    assign issuing  = (state_reg == ST_READ);
    assign last_tap = (kr_reg == K_LAST) && (kc_reg == K_LAST);

    always_comb begin
        rt = 15'(row_reg) + 15'(kr_reg) - 15'(HALF);
        ct = 15'(col_reg) + 15'(kc_reg) - 15'(HALF);
        if (rt[14]) begin
            ri = '0;
        end else if (rt > 15'(rows_m1)) begin
            ri = rows_m1;
        end else begin
            ri = RIW'(rt);
        end
        if (ct[14]) begin
            ci = '0;
        end else if (ct > 15'(cols_m1)) begin
            ci = cols_m1;
        end else begin
            ci = CIW'(ct);
        end
    end

    assign rd_addr   = AW'(ri) * AW'(MAX_COLS) + AW'(ci);
    assign ram_addr  = wr_fire ? wr_addr : rd_addr;
    assign coeff_sel = cfg.kernel[2'(kr_reg)][2'(kc_reg)];

    ccv_frame_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_ram (
        .aclk  (aclk),
        .en    (wr_fire || issuing),
        .we    (wr_fire),
        .addr  (ram_addr),
        .wdata (s_value),
        .rdata (ram_rdata)
    );

    // Truncate the Q.8 sum toward zero and reduce its magnitude modulo 255.
    // Since 256 is 1 modulo 255, the bytes of the magnitude can simply be added.
    always_comb begin
        acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        q_mag    = acc_mag[ACC_W-1:8];
        s1       = 10'(q_mag[7:0]) + 10'(q_mag[15:8]) + 10'(q_mag[19:16]);
        s2       = 9'(s1[7:0]) + 9'(s1[9:8]);
        mag_next = (s2 >= MOD_BASE) ? 8'(s2 - MOD_BASE) : s2[7:0];
    end

    // Restore the sign, then apply the upper bound and the lower bound.
    always_comb begin
        sv = neg_reg ? -signed'(10'(mag_reg)) : signed'(10'(mag_reg));
        cv = sv;
        if (cv > signed'({2'b00, cfg.max_brightness})) begin
            cv = signed'({2'b00, cfg.max_brightness});
        end
        if (cv < signed'({2'b00, cfg.min_brightness})) begin
            cv = signed'({2'b00, cfg.min_brightness});
        end
        out_value = oof_reg ? 8'd0 : cv[7:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_cmd == CMD_QUERY)) begin
                    state_next = inside_in ? ST_READ : ST_OUT;
                end
            end
            ST_READ: begin
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (prod_vld_reg && !rd_vld_reg) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            kr_reg       <= '0;
            kc_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= issuing;
            prod_vld_reg <= rd_vld_reg;

            if (accept) begin
                row_reg <= s_row;
                col_reg <= s_col;
                oof_reg <= !inside_in;
                acc_reg <= '0;
                kr_reg  <= '0;
                kc_reg  <= '0;
            end

            if (issuing) begin
                if (kc_reg == K_LAST) begin
                    kc_reg <= '0;
                    kr_reg <= kr_reg + 1'b1;
                end else begin
                    kc_reg <= kc_reg + 1'b1;
                end
            end

            coeff_d1_reg <= coeff_sel;
            prod_reg     <= signed'({1'b0, ram_rdata}) * coeff_d1_reg;
            if (prod_vld_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end

            if (state_reg == ST_MOD) begin
                mag_reg <= mag_next;
                neg_reg <= acc_reg[ACC_W-1];
            end

            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_value_reg  <= out_value;
                m_oof_reg    <= oof_reg;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_value  = m_value_reg;
    assign m_oof    = m_oof_reg;

    `ASSERT_SAME_CYCLE(a_write_only_on_accept, wr_fire, s_tvalid && s_tready,
                       "frame write without an accepted item")
    `ASSERT_SAME_CYCLE(a_error_value_zero, m_tvalid_reg && m_oof_reg, m_value_reg == 8'd0,
                       "out-of-frame result carries a nonzero value")
    `ASSERT_SAME_CYCLE(a_value_in_window,
                       m_tvalid_reg && !m_oof_reg && (cfg.min_brightness <= cfg.max_brightness),
                       (m_value_reg <= cfg.max_brightness) && (m_value_reg >= cfg.min_brightness),
                       "result outside the brightness window")
    `ASSERT_NEXT_CYCLE(a_query_leaves_idle, accept && (s_cmd == CMD_QUERY),
                       state_reg != ST_IDLE, "query accepted but engine stayed idle")

endmodule

`default_nettype wire

// ----- hdl/clamped_edge_2d_convolution_core.sv -----
`default_nettype none

// Replicated-border 2D smoothing core. The block holds a frame of 8-bit
// pixels in one single-port synchronous memory. An item with cmd 0 stores
// pixel_value at (pixel_row, pixel_col) and gives no result; a write outside
// the frame in use is dropped. An item with cmd 1 returns one result: the
// KERNEL_SIZE x KERNEL_SIZE sum of pixel times signed Q8.8 coefficient around
// the coordinate, with neighbor coordinates clamped to the frame edges, then
// truncated toward zero, reduced by a signed remainder modulo 255 and clamped
// to the brightness window (upper bound first, lower bound last). A query
// outside the frame returns value 0 with out_of_frame set. A write leaves the
// block ready, so writes may arrive back to back. A query inside the frame
// reads one memory entry per kernel tap through the single port, then drains
// the multiply pipeline, does the modulo reduction and makes the output
// hand-off before the block is ready for its next item; an out-of-frame
// query goes straight to the output hand-off. The result sits in an output
// register, so a new item is taken while the previous result waits; a query
// whose result finds that register still full holds in its last step until
// the register frees, and the input waits with it. Pixels that were never
// written read back as whatever the memory holds; there is no clearing pass
// after reset.
module clamped_edge_2d_convolution_core #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256,
    parameter int KERNEL_SIZE = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write port, register index as listed in ccv_pkg.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata,

    // Command items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pixel_row[7:0], pixel_col[15:8], pixel_value[23:16]
    input  wire logic [0:0]  s_tuser,   // cmd[0]

    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // smoothed_value[7:0]
    output logic [0:0]       m_tuser    // out_of_frame[0]
);

    import ccv_pkg::*;

    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Configuration registers.
    kernel_t    kernel_reg;
    logic [8:0] frame_rows_reg;
    logic [8:0] frame_cols_reg;
    logic [7:0] min_bright_reg;
    logic [7:0] max_bright_reg;

    logic [RIW-1:0] rows_m1;
    logic [CIW-1:0] cols_m1;
    win_cfg_t       cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg     <= '0;
            frame_rows_reg <= FRAME_SIZE_RESET;
            frame_cols_reg <= FRAME_SIZE_RESET;
            min_bright_reg <= 8'd0;
            max_bright_reg <= MAX_BRIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_KERNEL_ROW_0: kernel_reg[0]  <= cfg_wdata;
                CFG_KERNEL_ROW_1: kernel_reg[1]  <= cfg_wdata;
                CFG_KERNEL_ROW_2: kernel_reg[2]  <= cfg_wdata;
                CFG_KERNEL_ROW_3: kernel_reg[3]  <= cfg_wdata;
                CFG_FRAME_ROWS:   frame_rows_reg <= cfg_wdata[8:0];
                CFG_FRAME_COLS:   frame_cols_reg <= cfg_wdata[8:0];
                CFG_MIN_BRIGHT:   min_bright_reg <= cfg_wdata[7:0];
                CFG_MAX_BRIGHT:   max_bright_reg <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // The frame size in use saturates to 1..MAX; the engine works with the
    // last valid row and column index, which is also the clamp limit.
    always_comb begin
        if (frame_rows_reg == 9'd0) begin
            rows_m1 = '0;
        end else if (32'(frame_rows_reg) > MAX_ROWS) begin
            rows_m1 = RIW'(MAX_ROWS - 1);
        end else begin
            rows_m1 = RIW'(frame_rows_reg - 9'd1);
        end
        if (frame_cols_reg == 9'd0) begin
            cols_m1 = '0;
        end else if (32'(frame_cols_reg) > MAX_COLS) begin
            cols_m1 = CIW'(MAX_COLS - 1);
        end else begin
            cols_m1 = CIW'(frame_cols_reg - 9'd1);
        end
    end

    // Kernel first, then the lower and the upper bound, as the struct orders them.
    assign cfg = {kernel_reg, min_bright_reg, max_bright_reg};

    ccv_engine #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .rows_m1  (rows_m1),
        .cols_m1  (cols_m1),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser[0]),
        .s_row    (s_tdata[7:0]),
        .s_col    (s_tdata[15:8]),
        .s_value  (s_tdata[23:16]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (m_tdata),
        .m_oof    (m_tuser[0])
    );

endmodule

`default_nettype wire
